FILE: sv/lkv_pkg.sv
package lkv_pkg;

    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic
    {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } kind_t;

    // broadcast to every cell for the item in flight
    typedef struct packed
    {
        logic hit;   // key found somewhere in the row
        logic ins;   // put of a key not present
        logic full;  // occupancy has reached the capacity in force
    } cell_ctl_t;

endpackage

FILE: sv/lkv_ifs.sv
interface lkv_req_if #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkv_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;

    modport source (output valid, hit, read_value, evicted, input ready);
    modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

interface lkv_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: sv/lru_key_value_cache.sv
// A result is registered in the cycle its item is accepted and is offered on rsp from the next cycle.
// Throughput: one item per cycle; the whole row of cells compares and shifts
// in the accepting cycle, so the rate is set only by the output register draining.
// Reset empties every cell, clears occupancy and sets capacity to 16.
// The cell row is ordered by recency: cell 0 holds the most recent entry.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input logic clk,
    input logic rst_n,
    lkv_req_if.sink   req,
    lkv_rsp_if.source rsp,
    lkv_cfg_if.sink   cfg
);
    import lkv_pkg::*;

    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    logic [CAP_BITS-1:0]   cap_reg;
    logic [CNT_BITS-1:0]   occ_reg;
    logic [CNT_BITS-1:0]   occ_next;
    logic [CMP_BITS-1:0]   cap_ext;
    logic [CMP_BITS-1:0]   cap_eff;
    logic [CMP_BITS-1:0]   occ_ext;

    logic                  rsp_valid_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] rd_reg;
    logic                  ev_reg;

    logic                  fire;
    logic                  any_hit;
    logic                  is_put;
    cell_ctl_t             ctl;
    logic [VALUE_BITS-1:0] hit_data;
    logic [VALUE_BITS-1:0] head_data;

    logic                  cell_valid [ENTRIES];
    logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0] cell_data  [ENTRIES];
    logic [ENTRIES-1:0]    match_vec;
    logic [ENTRIES-1:0]    valid_vec;
    logic                  sfx_chain  [ENTRIES+1];
    logic [VALUE_BITS-1:0] rd_chain   [ENTRIES+1];

    // capacity in force: zero acts as one, above ENTRIES acts as ENTRIES
    always_comb
    begin
        cap_ext = CMP_BITS'(cap_reg);
        occ_ext = CMP_BITS'(occ_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CMP_BITS'(1);
        end
        else if (cap_ext > CMP_BITS'(ENTRIES))
        begin
            cap_eff = CMP_BITS'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign cfg.ready = 1'b1;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign is_put    = (req.kind == KIND_PUT);

    assign sfx_chain[ENTRIES] = 1'b0;
    assign rd_chain[0]        = '0;
    assign any_hit            = sfx_chain[0];
    assign hit_data           = rd_chain[ENTRIES];
    assign head_data          = is_put ? req.value : hit_data;

    assign ctl.hit  = fire && any_hit;
    assign ctl.ins  = fire && !any_hit && is_put;
    assign ctl.full = (occ_ext >= cap_eff);

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic                  pv;
        logic [KEY_BITS-1:0]   pk;
        logic [VALUE_BITS-1:0] pd;

        if (i == 0)
        begin : g_head
            assign pv = 1'b1;
            assign pk = req.key;
            assign pd = head_data;
        end
        else
        begin : g_body
            assign pv = cell_valid[i-1];
            assign pk = cell_key[i-1];
            assign pd = cell_data[i-1];
        end

        lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .req_key    (req.key),
            .prev_valid (pv),
            .prev_key   (pk),
            .prev_data  (pd),
            .sfx_in     (sfx_chain[i+1]),
            .sfx_out    (sfx_chain[i]),
            .rd_in      (rd_chain[i]),
            .rd_out     (rd_chain[i+1]),
            .match      (match_vec[i]),
            .valid      (cell_valid[i]),
            .key        (cell_key[i]),
            .data       (cell_data[i])
        );

        assign valid_vec[i] = cell_valid[i];
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.ins && !ctl.full)
        begin
            occ_next = occ_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
            occ_reg <= occ_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hit_reg <= any_hit;
            rd_reg  <= (any_hit && !is_put) ? hit_data : '0;
            ev_reg  <= !any_hit && is_put && ctl.full;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = hit_reg;
    assign rsp.read_value = rd_reg;
    assign rsp.evicted    = ev_reg;

    // valid cells form one run from the head, as long as the occupancy count
    a_occ_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy disagrees with valid cells");

    // a valid cell behind an empty one would be a gap
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & ~(valid_vec << 1)) & ~ENTRIES'(1)) == '0 || valid_vec == '0)
        else $error("gap in the valid run of cells");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key present in more than one cell");

    a_evict_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && ev_reg |-> !hit_reg && rd_reg == '0)
        else $error("eviction reported with a hit");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != $past(occ_reg) |=> 1'b1 ##0 occ_reg <= CNT_BITS'(ENTRIES))
        else $error("occupancy beyond the row");

endmodule

FILE: sv/lkv_cell.sv
module lkv_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkv_pkg::cell_ctl_t    ctl,
    input  logic [KEY_BITS-1:0]   req_key,
    // neighbour towards the most recent end
    input  logic                  prev_valid,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [VALUE_BITS-1:0] prev_data,
    // match and read data chains
    input  logic                  sfx_in,
    output logic                  sfx_out,
    input  logic [VALUE_BITS-1:0] rd_in,
    output logic [VALUE_BITS-1:0] rd_out,
    output logic                  match,
    output logic                  valid,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] data
);
    import lkv_pkg::*;

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] data_reg;
    logic                  shift;

    assign match   = valid_reg && (key_reg == req_key);
    assign sfx_out = match | sfx_in;
    assign rd_out  = rd_in | (match ? data_reg : '0);

    // hit: every cell from the head down to the hit one moves one place back
    // insert: the whole valid run moves back; when full the last entry drops
    assign shift = (ctl.hit & sfx_out)
                 | (ctl.ins & prev_valid & (valid_reg | ~ctl.full));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg  <= prev_key;
            data_reg <= prev_data;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign data  = data_reg;

endmodule
